// ===== hw/rtl/gbfd_pkg.sv =====
package gbfd_pkg;

   localparam int ByteWidth  = 8;
   localparam int IndexWidth = 22;
   localparam int CodeWidth  = 21;
   localparam int SigWidth   = 2;
   localparam int RangeCount = 13;
   localparam int QueueDepth = 2;

   // Radices of the byte positions within one sequence
   localparam int RadixTen        = 10;
   localparam int RadixOneTwentySix = 126;

   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [IndexWidth-1:0] index_type;
   typedef logic [CodeWidth-1:0]  code_type;
   typedef logic [SigWidth-1:0]   sig_type;

   // One finished linear index travelling from front to back
   typedef struct packed {
      logic      valid;
      index_type index;
   } entry_type;

   localparam index_type RangeLo [RangeCount] = '{
      22'd1688038, 22'd1696437, 22'd1700191, 22'd1701916, 22'd1703065,
      22'd1703947, 22'd1704636, 22'd1705179, 22'd1706261, 22'd1720768,
      22'd1725296, 22'd1726612, 22'd1876218
   };

   localparam index_type RangeHi [RangeCount] = '{
      22'd1695139, 22'd1698546, 22'd1700955, 22'd1702800, 22'd1703535,
      22'd1704319, 22'd1705076, 22'd1705881, 22'd1720686, 22'd1725062,
      22'd1726325, 22'd1726637, 22'd2924793
   };

   localparam code_type RangeBase [RangeCount] = '{
      21'h00452, 21'h02643, 21'h0361B, 21'h03CE1, 21'h04160,
      21'h044D7, 21'h0478E, 21'h049B8, 21'h09FA6, 21'h0E865,
      21'h0FA2A, 21'h0FFE6, 21'h10000
   };

   // Code point minus index, modulo 2^IndexWidth, per range
   function automatic index_type range_offset(input int k);
      range_offset = index_type'({1'b0, RangeBase[k]}) - RangeLo[k];
   endfunction

endpackage

// ===== hw/rtl/gbfd_ifs.sv =====
interface gbfd_req_if;
   logic               valid;
   logic               ready;
   gbfd_pkg::byte_type in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface gbfd_rsp_if;
   logic               valid;
   logic               ready;
   gbfd_pkg::code_type code_point;
   gbfd_pkg::sig_type  sig_bytes;
   logic               invalid;

   modport source (output valid, output code_point, output sig_bytes, output invalid,
                   input ready);
   modport sink   (input valid, input code_point, input sig_bytes, input invalid,
                   output ready);
endinterface

// ===== hw/rtl/gbfd_front.sv =====
module gbfd_front (
   input  logic                clock,
   input  logic                reset,
   gbfd_req_if.sink            req,
   input  logic                queue_full,
   output gbfd_pkg::entry_type push
);

   localparam logic [1:0] PhaseFirst  = 2'd0;
   localparam logic [1:0] PhaseSecond = 2'd1;
   localparam logic [1:0] PhaseThird  = 2'd2;
   localparam logic [1:0] PhaseLast   = 2'd3;

   logic [1:0]          phase_ff, phase_in;
   gbfd_pkg::index_type accum_ff, accum_in;
   gbfd_pkg::index_type sum;
   logic                take;

   // only the fourth word needs room in the queue
   assign req.ready = (phase_ff != PhaseLast) || !queue_full;
   assign take      = req.valid && req.ready;
   assign sum       = accum_ff + gbfd_pkg::index_type'(req.in_byte);

   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      if (take) begin
         case (phase_ff)
            PhaseFirst: begin
               accum_in = gbfd_pkg::index_type'(req.in_byte)
                        * gbfd_pkg::index_type'(gbfd_pkg::RadixTen);
               phase_in = PhaseSecond;
            end
            PhaseSecond: begin
               accum_in = sum * gbfd_pkg::index_type'(gbfd_pkg::RadixOneTwentySix);
               phase_in = PhaseThird;
            end
            PhaseThird: begin
               accum_in = sum * gbfd_pkg::index_type'(gbfd_pkg::RadixTen);
               phase_in = PhaseLast;
            end
            default: begin
               accum_in = sum;
               phase_in = PhaseFirst;
            end
         endcase
      end
   end

   assign push.valid = take && (phase_ff == PhaseLast);
   assign push.index = sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhaseFirst;
         accum_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
      end
   end

   a_wrap: assert property (@(posedge clock) disable iff (reset)
      take && (phase_ff == PhaseLast) |=> phase_ff == PhaseFirst)
      else $error("phase did not wrap after the fourth word");

endmodule

// ===== hw/rtl/gbfd_queue.sv =====
module gbfd_queue #(
   parameter int DEPTH = gbfd_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  gbfd_pkg::entry_type push,
   input  logic                pop,
   output gbfd_pkg::entry_type head,
   output logic                full
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);

   gbfd_pkg::index_type mem [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == CntWidth'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.index = mem[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push.index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(DEPTH))
      else $error("queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("push into a full queue");

endmodule

// ===== hw/rtl/gbfd_back.sv =====
module gbfd_back (
   input  logic                clock,
   input  logic                reset,
   input  gbfd_pkg::entry_type head,
   output logic                pop,
   gbfd_rsp_if.source          rsp
);

   logic [gbfd_pkg::RangeCount-1:0] hit;
   gbfd_pkg::index_type             offset;
   gbfd_pkg::index_type             cp_sum;
   gbfd_pkg::code_type              cp;
   gbfd_pkg::sig_type               sig;
   logic                            miss;

   logic                valid_ff, valid_in;
   gbfd_pkg::code_type  code_ff;
   gbfd_pkg::sig_type   sig_ff;
   logic                inv_ff;

   // ranges are disjoint, so at most one hit; OR its offset in
   always_comb begin
      offset = '0;
      for (int k = 0; k < gbfd_pkg::RangeCount; k++) begin
         hit[k] = (head.index >= gbfd_pkg::RangeLo[k]) &&
                  (head.index <= gbfd_pkg::RangeHi[k]);
         if (hit[k]) begin
            offset = offset | gbfd_pkg::range_offset(k);
         end
      end
   end

   assign miss   = (hit == '0);
   assign cp_sum = head.index + offset;

   always_comb begin
      cp = miss ? '0 : cp_sum[gbfd_pkg::CodeWidth-1:0];
      if (cp[gbfd_pkg::CodeWidth-1:16] != '0) begin
         sig = 2'd3;
      end else if (cp[15:8] != '0) begin
         sig = 2'd2;
      end else if (cp[7:0] != '0) begin
         sig = 2'd1;
      end else begin
         sig = 2'd0;
      end
   end

   // advance when the output register is empty or being drained
   assign pop      = head.valid && (!valid_ff || rsp.ready);
   assign valid_in = pop || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (pop) begin
         code_ff <= cp;
         sig_ff  <= sig;
         inv_ff  <= miss;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.code_point = code_ff;
   assign rsp.sig_bytes  = sig_ff;
   assign rsp.invalid    = inv_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && inv_ff |-> (code_ff == '0) && (sig_ff == '0))
      else $error("invalid result carries a code point");

   a_pop_lands: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("popped index did not reach the output register");

endmodule

// ===== hw/rtl/gb18030_four_byte_decoder.sv =====
// Channel  Port     Dir  Payload                              Accepted when
// -------  -------  ---  -----------------------------------  -------------------
// request  req_ch   in   in_byte[7:0]                         valid && ready
// response rsp_ch   out  code_point[20:0] sig_bytes[1:0] inv  valid && ready
//
// One word per cycle in, one result per four words out, with no bubbles while the
// queue has room. A result goes from its fourth word through a queue write, then the
// range match into the output register; the 13-way range match sets that path.
// Reset is synchronous and clears the byte phase, the queue and the output valid.
// A stalled response fills the QUEUE_DEPTH-entry queue; only a fourth word
// waits on a full queue, the first three words of a sequence are always taken.
module gb18030_four_byte_decoder #(
   parameter int QUEUE_DEPTH = gbfd_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   gbfd_req_if.sink    req_ch,
   gbfd_rsp_if.source  rsp_ch
);

   // finished index from the folding front end
   gbfd_pkg::entry_type push;
   // oldest queued index, seen by the range matcher
   gbfd_pkg::entry_type head;
   logic                queue_full;
   logic                pop;

   // fold bytes into the linear index; emit it on the fourth word
   gbfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .queue_full (queue_full),
      .push       (push)
   );

   // decouple folding from lookup so each side stalls on its own
   gbfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   // match against the range table, form the code point, hold it for the sink
   gbfd_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule

// ===== bench/tb_gb18030_four_byte_decoder.sv =====
module tb_gb18030_four_byte_decoder;

   // One decoded character as it leaves the response channel
   typedef struct packed {
      gbfd_pkg::code_type code_point;
      gbfd_pkg::sig_type  sig_bytes;
      logic               invalid;
   } char_type;

   // Four raw words of one sequence; element 0 goes out first
   typedef logic [3:0][7:0] quad_type;

   // One row of the directed table: the words, and a hand-typed result where
   // the answer is obvious; otherwise the decoder model below supplies it
   typedef struct packed {
      quad_type raw;
      logic     typed;
      char_type want;
   } row_type;

   localparam int          SpanCount = 13;
   localparam int unsigned IndexMax  = 3537105;   // four words of 255

   // GB18030 four-byte ranges: first index, last index, code point of first
   localparam int unsigned SpanLo [SpanCount] = '{
      1688038, 1696437, 1700191, 1701916, 1703065, 1703947, 1704636,
      1705179, 1706261, 1720768, 1725296, 1726612, 1876218
   };
   localparam int unsigned SpanHi [SpanCount] = '{
      1695139, 1698546, 1700955, 1702800, 1703535, 1704319, 1705076,
      1705881, 1720686, 1725062, 1726325, 1726637, 2924793
   };
   localparam int unsigned SpanBase [SpanCount] = '{
      'h00452, 'h02643, 'h0361B, 'h03CE1, 'h04160, 'h044D7, 'h0478E,
      'h049B8, 'h09FA6, 'h0E865, 'h0FA2A, 'h0FFE6, 'h10000
   };

   localparam int ClockHalf   = 4;
   localparam int ResetCycles = 10;
   localparam int PhaseSeqs   = 65;    // random sequences per idling phase
   localparam int HoldSeqs    = 20;    // sequences pushed against a held receiver
   localparam int HoldCycles  = 300;
   localparam int DrainCycles = 16;    // slack after the last character drains

   logic clock;
   logic reset;

   gbfd_req_if req_ch ();
   gbfd_rsp_if rsp_ch ();

   gb18030_four_byte_decoder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #ClockHalf;
      clock = 1'b1;
      #ClockHalf;
   end

   // Decoder model state: position within the sequence and the partial index
   logic [1:0]  seq_pos;
   int unsigned partial_index;

   // Characters still owed by the block, oldest first
   char_type pending_chars [$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;

   int words_sent;
   int seqs_sent;
   int chars_checked;
   int invalid_seen;
   int supplementary_seen;
   int mismatches;

   // Fold one word into the partial index; on the fourth word, map the index
   // through the range table and hand back the character it stands for.
   function automatic bit fold_byte(input gbfd_pkg::byte_type b, output char_type ch);
      int unsigned v;
      int unsigned cp;
      v  = b;
      ch = '0;
      case (seq_pos)
         2'd0: begin
            partial_index = (v * 10) & 32'h3F_FFFF;
            seq_pos = 2'd1;
            return 1'b0;
         end
         2'd1: begin
            partial_index = ((partial_index + v) * 126) & 32'h3F_FFFF;
            seq_pos = 2'd2;
            return 1'b0;
         end
         2'd2: begin
            partial_index = ((partial_index + v) * 10) & 32'h3F_FFFF;
            seq_pos = 2'd3;
            return 1'b0;
         end
         default: begin
            partial_index = (partial_index + v) & 32'h3F_FFFF;
            seq_pos = 2'd0;
         end
      endcase
      // No range hit: flag it and leave code point and size at zero
      ch.invalid = 1'b1;
      for (int k = 0; k < SpanCount; k++) begin
         if (partial_index >= SpanLo[k] && partial_index <= SpanHi[k]) begin
            cp            = (SpanBase[k] + (partial_index - SpanLo[k])) & 32'h1F_FFFF;
            ch.code_point = gbfd_pkg::code_type'(cp);
            ch.invalid    = 1'b0;
            ch.sig_bytes  = (cp > 'hFFFF) ? 2'd3 : (cp > 'hFF) ? 2'd2 :
                            (cp > 0) ? 2'd1 : 2'd0;
            return 1'b1;
         end
      end
      return 1'b1;
   endfunction

   // Turn a linear index back into four words. With scatter set, trade weight
   // between neighboring positions so the words reach well above their base
   // radix while the index stays the same.
   function automatic quad_type split_index(input int unsigned idx, input bit scatter);
      int b0, b1, b2, b3, r, t;
      quad_type q;
      b0 = idx / 12600;
      r  = idx % 12600;
      b1 = r / 1260;
      r  = r % 1260;
      b2 = r / 10;
      b3 = r % 10;
      if (scatter) begin
         t = $urandom_range((b0 < 24) ? b0 : 24, 0);
         b0 -= t;
         b1 += 10 * t;
         t = $urandom_range((b1 < 1) ? b1 : 1, 0);
         b1 -= t;
         b2 += 126 * t;
         t = $urandom_range((b2 < (255 - b3) / 10) ? b2 : (255 - b3) / 10, 0);
         b2 -= t;
         b3 += 10 * t;
      end
      q[0] = b0[7:0];
      q[1] = b1[7:0];
      q[2] = b2[7:0];
      q[3] = b3[7:0];
      return q;
   endfunction

   // Pick an index that lands on range edges, just outside them, inside them,
   // or anywhere in the reachable space.
   function automatic int unsigned pick_index();
      int k;
      k = $urandom_range(SpanCount - 1, 0);
      case ($urandom_range(7, 0))
         0: return SpanLo[k];
         1: return SpanHi[k];
         2: return SpanLo[k] - 1;
         3: return SpanHi[k] + 1;
         4: return $urandom_range(IndexMax, 0);
         default: return SpanLo[k] + $urandom_range(SpanHi[k] - SpanLo[k], 0);
      endcase
   endfunction

   // Offer one word from a falling edge, idling first at random. Return at the
   // falling edge after the word is taken, with valid still high so the next
   // call either keeps it up or drops it with a single assignment.
   task automatic send_word(input gbfd_pkg::byte_type b, input bit typed,
                            input char_type want);
      char_type got;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      if (fold_byte(b, got))
         pending_chars.push_back(typed ? want : got);
      @(negedge clock);
   endtask

   task automatic send_sequence(input quad_type q, input bit typed, input char_type want);
      for (int i = 0; i < 4; i++)
         send_word(q[i], typed && i == 3, want);
      seqs_sent++;
   endtask

   // Three quarters well-formed picks, the rest four words of pure noise
   task automatic send_random_sequence();
      quad_type q;
      if ($urandom_range(3, 0) != 0)
         q = split_index(pick_index(), $urandom_range(1, 0));
      else
         q = quad_type'($urandom());
      send_sequence(q, 1'b0, '0);
   endtask

   // Hold the sender until every owed character has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_chars.size() != 0)
         @(negedge clock);
   endtask

   // Receiver: drop ready at random per the stall rate, or for a counted
   // stretch when a hold-off is requested.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
         end
      end
   end

   // Check every taken character against the oldest one owed
   always @(posedge clock) begin : check_rsp
      char_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected character: code_point %h sig_bytes %0d invalid %b",
                   rsp_ch.code_point, rsp_ch.sig_bytes, rsp_ch.invalid);
            mismatches++;
         end else begin
            want = pending_chars.pop_front();
            chars_checked++;
            if (want.invalid)
               invalid_seen++;
            if (want.sig_bytes == 2'd3)
               supplementary_seen++;
            if (rsp_ch.code_point !== want.code_point) begin
               $error("code_point: expected %h, got %h", want.code_point, rsp_ch.code_point);
               mismatches++;
            end
            if (rsp_ch.sig_bytes !== want.sig_bytes) begin
               $error("sig_bytes: expected %0d, got %0d", want.sig_bytes, rsp_ch.sig_bytes);
               mismatches++;
            end
            if (rsp_ch.invalid !== want.invalid) begin
               $error("invalid: expected %b, got %b", want.invalid, rsp_ch.invalid);
               mismatches++;
            end
         end
      end
   end

   // Hard stop well past the slowest legal run
   initial begin
      #(2 * ClockHalf * 400000);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      row_type directed_rows [$];
      int      idle_mix [4];
      int      stall_mix [4];

      seq_pos            = 2'd0;
      partial_index      = 0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      hold_left          = 0;
      words_sent         = 0;
      seqs_sent          = 0;
      chars_checked      = 0;
      invalid_seen       = 0;
      supplementary_seen = 0;
      mismatches         = 0;

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = '0;

      // Directed table: all-zero and all-ones words fall outside every range;
      // the first and last index of the table, the top of the basic plane and the first
      // supplementary index have obvious answers; plain lead/trail bytes go to the model.
      directed_rows.push_back('{32'h0000_0000, 1'b1, '{21'h0, 2'd0, 1'b1}});
      directed_rows.push_back('{32'hFFFF_FFFF, 1'b1, '{21'h0, 2'd0, 1'b1}});
      directed_rows.push_back('{split_index(1688038, 0), 1'b1, '{21'h00452, 2'd2, 1'b0}});
      directed_rows.push_back('{split_index(1726637, 0), 1'b1, '{21'h0FFFF, 2'd2, 1'b0}});
      directed_rows.push_back('{split_index(1876218, 0), 1'b1, '{21'h10000, 2'd3, 1'b0}});
      directed_rows.push_back('{split_index(2924793, 0), 1'b1, '{21'h10FFFF, 2'd3, 1'b0}});
      directed_rows.push_back('{{8'd48, 8'd129, 8'd48, 8'd129}, 1'b0, '0});

      // Idling phases: none, sender idle, receiver stalling, both
      idle_mix  = '{0, 86, 0, 17};
      stall_mix = '{0, 0, 86, 17};

      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_sequence(directed_rows[i].raw, directed_rows[i].typed, directed_rows[i].want);

      // Pause the sender until the directed characters are all back
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_mix[p];
         recv_stall_pct = stall_mix[p];
         repeat (PhaseSeqs) send_random_sequence();
      end

      // Hold the receiver off for a long stretch while words keep coming;
      // the queue fills and the block must stall its input on a fourth word
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = HoldCycles;
      repeat (HoldSeqs) send_random_sequence();

      wait_drained();
      repeat (DrainCycles) @(negedge clock);

      $display("Sent %0d words in %0d sequences; checked %0d characters", words_sent,
               seqs_sent, chars_checked);
      $display("  of which %0d out of range and %0d beyond the basic plane",
               invalid_seen, supplementary_seen);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/gbfd_pkg.sv
hw/rtl/gbfd_ifs.sv
hw/rtl/gbfd_front.sv
hw/rtl/gbfd_queue.sv
hw/rtl/gbfd_back.sv
hw/rtl/gb18030_four_byte_decoder.sv
bench/tb_gb18030_four_byte_decoder.sv
